// ===== sv/stopwatch_countdown_timer_defines.svh =====
// Assertion macros used by the stopwatch countdown timer checker.
`ifndef STOPWATCH_COUNTDOWN_TIMER_DEFINES_SVH
`define STOPWATCH_COUNTDOWN_TIMER_DEFINES_SVH

// Same-cycle implication, masked while reset is asserted.
`define STC_ASSERT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, masked while reset is asserted.
`define STC_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that also holds across reset.
`define STC_ASSERT_NEXT_ANY(lbl, clk, ante, cons, msg) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/stc_pkg.sv =====
// Shared types, codes and constants of the stopwatch countdown timer.
`default_nettype none

package stc_pkg;

    // Field widths
    localparam int OPCODE_W      = 4;
    localparam int ELAPSED_W     = 32;
    localparam int PRESET_W      = 30;
    localparam int TIME_FIELD_W  = 33;
    localparam int CFG_DATA_W    = 33;
    localparam int CFG_INDEX_W   = 1;
    localparam int MS_MULT_W     = 10;
    localparam int PRESET_PROD_W = PRESET_W + MS_MULT_W;

    // Default internal time width
    localparam int TIME_BITS_DEF = 33;

    // Reset values and scale
    localparam logic [CFG_DATA_W-1:0]   MAX_MIN_RESET   = 33'd5999990000;
    localparam logic [CFG_DATA_W-1:0]   MAX_SEC_RESET   = 33'd999990000;
    localparam logic [TIME_FIELD_W-1:0] PRESET_RESET_US = 33'd300000;
    localparam logic [MS_MULT_W-1:0]    US_PER_MS       = 10'd1000;

    typedef enum logic [OPCODE_W-1:0] {
        OP_TICK      = 4'd0,
        OP_START     = 4'd1,
        OP_STOP      = 4'd2,
        OP_RESET     = 4'd3,
        OP_PRESET    = 4'd4,
        OP_STOPWATCH = 4'd5,
        OP_MINUTES   = 4'd6,
        OP_SECONDS   = 4'd7,
        OP_CLOCK     = 4'd8
    } opcode_t;

    typedef enum logic [1:0] {
        PH_RESET   = 2'd0,
        PH_RUNNING = 2'd1,
        PH_PAUSED  = 2'd2,
        PH_STOPPED = 2'd3
    } phase_t;

    typedef enum logic [1:0] {
        MODE_STOPWATCH = 2'd0,
        MODE_COUNTDOWN = 2'd1,
        MODE_CLOCK     = 2'd2
    } mode_t;

    typedef enum logic {
        UNIT_MINUTES = 1'b0,
        UNIT_SECONDS = 1'b1
    } unit_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_MAX_MINUTES = 1'b0,
        CFG_MAX_SECONDS = 1'b1
    } cfg_index_t;

    // One input word
    typedef struct packed {
        logic [OPCODE_W-1:0]  opcode;
        logic [ELAPSED_W-1:0] elapsed_us;
        logic [PRESET_W-1:0]  preset_ms;
    } stc_item_t;

    // One result word
    typedef struct packed {
        phase_t                  run_state;
        mode_t                   count_mode;
        unit_t                   display_units;
        logic [TIME_FIELD_W-1:0] time_us;
        logic                    save_request;
        logic                    stop_report;
    } stc_result_t;

    // Display-unit time limits
    typedef struct packed {
        logic [CFG_DATA_W-1:0] max_minutes_us;
        logic [CFG_DATA_W-1:0] max_seconds_us;
    } stc_limits_t;

endpackage

`default_nettype wire

// ===== sv/stc_cfg.sv =====
// Configuration registers holding the display-unit time limits.
`default_nettype none

module stc_cfg
    import stc_pkg::*;
(
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data,
    output stc_limits_t                 limits
);

    stc_limits_t limits_reg;

    // Always able to take a write
    assign cfg_ready = 1'b1;
    assign limits    = limits_reg;

    // Register file write
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limits_reg.max_minutes_us <= MAX_MIN_RESET;
            limits_reg.max_seconds_us <= MAX_SEC_RESET;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index_t'(cfg_index))
                CFG_MAX_MINUTES: limits_reg.max_minutes_us <= cfg_data;
                CFG_MAX_SECONDS: limits_reg.max_seconds_us <= cfg_data;
                default: ;
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== sv/stc_in_stage.sv =====
// Input register stage: captures one command or tick word.
`default_nettype none

module stc_in_stage
    import stc_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      s_valid,
    output logic           s_ready,
    input  wire stc_item_t s_item,
    output logic           item_valid,
    input  wire logic      item_ready,
    output stc_item_t      item
);

    logic      valid_reg;
    stc_item_t item_reg;

    // Take a new word whenever the held one leaves or none is held
    assign s_ready    = !valid_reg || item_ready;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_ready) begin
            valid_reg <= s_valid;
        end
    end

    // Payload, no reset
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= s_item;
        end
    end

endmodule

`default_nettype wire

// ===== sv/stc_core.sv =====
// Timer state, single-pass command/tick update and result register.
`default_nettype none

module stc_core
    import stc_pkg::*;
#(
    parameter int TIME_BITS = TIME_BITS_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        item_valid,
    output logic             item_ready,
    input  wire stc_item_t   item,
    input  wire stc_limits_t limits,
    output logic             m_valid,
    input  wire logic        m_ready,
    output stc_result_t      result
);

    // Compare widths: one bit of headroom over time and limit fields
    localparam int CW  = ((TIME_BITS > TIME_FIELD_W) ? TIME_BITS : TIME_FIELD_W) + 1;
    localparam int PCW = (TIME_BITS > PRESET_PROD_W) ? TIME_BITS : PRESET_PROD_W;
    localparam logic [TIME_BITS-1:0] TIME_MASK = '1;

    phase_t              phase_reg,  phase_next;
    mode_t               mode_reg,   mode_next;
    unit_t               unit_reg,   unit_next;
    logic [TIME_BITS-1:0] cur_reg,   cur_next;
    logic [TIME_BITS-1:0] preset_reg, preset_next;
    logic                out_valid_reg;
    stc_result_t         res_reg,    res_next;

    logic                 fire;
    logic [CW-1:0]        cur_w, el_w, t_w, lim_w, lim_cap_w, mask_w, adv_w;
    logic [CFG_DATA_W-1:0] lim_sel;
    logic                 adv_stop;
    logic [TIME_BITS-1:0] adv_time;
    logic [PRESET_PROD_W-1:0] prod;
    logic [PCW-1:0]       prod_w, pmin_w, pmask_w, psat_w, pcap_w;
    logic [TIME_BITS-1:0] preset_cap;
    logic                 save, report;
    logic [CW-1:0]        time_ext;

    assign item_ready = !out_valid_reg || m_ready;
    assign fire       = item_valid && item_ready;
    assign m_valid    = out_valid_reg;
    assign result     = res_reg;

    // Advance: add or subtract elapsed, clamp at zero and at the unit limit
    always_comb begin
        cur_w  = CW'(cur_reg);
        el_w   = CW'(item.elapsed_us);
        mask_w = CW'(TIME_MASK);
        if (mode_reg == MODE_STOPWATCH) begin
            t_w = cur_w + el_w;
        end else begin
            t_w = (el_w >= cur_w) ? '0 : (cur_w - el_w);
        end
        lim_sel   = (unit_reg == UNIT_MINUTES) ? limits.max_minutes_us
                                               : limits.max_seconds_us;
        lim_w     = CW'(lim_sel);
        lim_cap_w = (lim_w > mask_w) ? mask_w : lim_w;
        if (t_w == '0) begin
            adv_w    = '0;
            adv_stop = 1'b1;
        end else if (t_w > lim_cap_w) begin
            adv_w    = lim_cap_w;
            adv_stop = 1'b1;
        end else begin
            adv_w    = t_w;
            adv_stop = 1'b0;
        end
        adv_time = adv_w[TIME_BITS-1:0];
    end

    // Preset: ms to us, saturate at the minutes limit and the time range
    always_comb begin
        prod       = PRESET_PROD_W'(item.preset_ms) * PRESET_PROD_W'(US_PER_MS);
        prod_w     = PCW'(prod);
        pmin_w     = PCW'(limits.max_minutes_us);
        pmask_w    = PCW'(TIME_MASK);
        psat_w     = (prod_w > pmin_w) ? pmin_w : prod_w;
        pcap_w     = (psat_w > pmask_w) ? pmask_w : psat_w;
        preset_cap = pcap_w[TIME_BITS-1:0];
    end

    // Command decode and next state
    always_comb begin
        phase_next  = phase_reg;
        mode_next   = mode_reg;
        unit_next   = unit_reg;
        cur_next    = cur_reg;
        preset_next = preset_reg;
        save        = 1'b0;
        report      = 1'b0;
        case (opcode_t'(item.opcode))
            OP_TICK: begin
                if (phase_reg == PH_RUNNING) begin
                    cur_next = adv_time;
                    if (adv_stop) begin
                        phase_next = PH_STOPPED;
                    end
                end
            end
            OP_START: begin
                phase_next = PH_RUNNING;
            end
            OP_STOP: begin
                if (phase_reg == PH_RUNNING) begin
                    cur_next   = adv_time;
                    phase_next = PH_PAUSED;
                    report     = 1'b1;
                end
            end
            OP_RESET: begin
                if (phase_reg != PH_RUNNING) begin
                    case (mode_reg)
                        MODE_STOPWATCH: cur_next = '0;
                        MODE_COUNTDOWN: cur_next = preset_reg;
                        default: ;
                    endcase
                    phase_next = PH_RESET;
                end
            end
            OP_PRESET: begin
                save        = (mode_reg != MODE_COUNTDOWN) || (preset_cap != preset_reg);
                preset_next = preset_cap;
                mode_next   = MODE_COUNTDOWN;
                phase_next  = PH_STOPPED;
                cur_next    = preset_cap;
            end
            OP_STOPWATCH: begin
                save      = (mode_reg != MODE_STOPWATCH);
                mode_next = MODE_STOPWATCH;
                cur_next  = '0;
            end
            OP_MINUTES: begin
                save      = (unit_reg != UNIT_MINUTES);
                unit_next = UNIT_MINUTES;
            end
            OP_SECONDS: begin
                save      = (unit_reg != UNIT_SECONDS);
                unit_next = UNIT_SECONDS;
            end
            OP_CLOCK: begin
                save      = (mode_reg != MODE_CLOCK);
                mode_next = MODE_CLOCK;
            end
            default: ;
        endcase
    end

    // Result word
    always_comb begin
        time_ext               = CW'(cur_next);
        res_next.run_state     = phase_next;
        res_next.count_mode    = mode_next;
        res_next.display_units = unit_next;
        res_next.time_us       = time_ext[TIME_FIELD_W-1:0];
        res_next.save_request  = save;
        res_next.stop_report   = report;
    end

    // Timer state and result valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_RESET;
            mode_reg      <= MODE_STOPWATCH;
            unit_reg      <= UNIT_MINUTES;
            cur_reg       <= '0;
            preset_reg    <= TIME_BITS'(PRESET_RESET_US);
            out_valid_reg <= 1'b0;
        end else begin
            if (fire) begin
                phase_reg  <= phase_next;
                mode_reg   <= mode_next;
                unit_reg   <= unit_next;
                cur_reg    <= cur_next;
                preset_reg <= preset_next;
            end
            if (item_ready) begin
                out_valid_reg <= item_valid;
            end
        end
    end

    // Result payload, no reset
    always_ff @(posedge aclk) begin
        if (fire) begin
            res_reg <= res_next;
        end
    end

endmodule

`default_nettype wire

// ===== sv/stopwatch_countdown_timer.sv =====
// Stopwatch / countdown timer: an accepted word passes the input register, then the result register.
// Throughput is one word per cycle while the output is not stalled; the whole time update is one pass of
// add/compare/mux logic between the input register and the result register.
// Output stalls back up through the result and input registers only.
// Synchronous active-low reset: run state reset, stopwatch mode, minutes,
// time 0, preset 300000 us, limits at their defaults, no words in flight.
`default_nettype none

module stopwatch_countdown_timer
    import stc_pkg::*;
#(
    parameter int TIME_BITS = TIME_BITS_DEF
) (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    s_valid,
    output logic                         s_ready,
    input  wire logic [OPCODE_W-1:0]     s_opcode,
    input  wire logic [ELAPSED_W-1:0]    s_elapsed_us,
    input  wire logic [PRESET_W-1:0]     s_preset_ms,
    output logic                         m_valid,
    input  wire logic                    m_ready,
    output logic [1:0]                   m_run_state,
    output logic [1:0]                   m_count_mode,
    output logic                         m_display_units,
    output logic [TIME_FIELD_W-1:0]      m_time_us,
    output logic                         m_save_request,
    output logic                         m_stop_report,
    input  wire logic                    cfg_valid,
    output logic                         cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0]   cfg_data
);

    stc_item_t   s_item, item;
    logic        item_valid, item_ready;
    stc_limits_t limits;
    stc_result_t result;

    assign s_item.opcode     = s_opcode;
    assign s_item.elapsed_us = s_elapsed_us;
    assign s_item.preset_ms  = s_preset_ms;

    stc_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .limits    (limits)
    );

    stc_in_stage u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_item     (s_item),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item)
    );

    stc_core #(
        .TIME_BITS (TIME_BITS)
    ) u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .limits     (limits),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .result     (result)
    );

    // Unpack result word onto ports
    assign m_run_state     = result.run_state;
    assign m_count_mode    = result.count_mode;
    assign m_display_units = result.display_units;
    assign m_time_us       = result.time_us;
    assign m_save_request  = result.save_request;
    assign m_stop_report   = result.stop_report;

endmodule

`default_nettype wire

// ===== sv/stc_checker.sv =====
// Port-level checker for the stopwatch countdown timer, with its bind.
`default_nettype none
`include "stopwatch_countdown_timer_defines.svh"

module stc_checker
    import stc_pkg::*;
(
    input wire logic                    aclk,
    input wire logic                    aresetn,
    input wire logic                    s_ready,
    input wire logic                    m_valid,
    input wire logic                    m_ready,
    input wire logic [1:0]              m_run_state,
    input wire logic [TIME_FIELD_W-1:0] m_time_us,
    input wire logic                    m_save_request,
    input wire logic                    m_stop_report
);

    // A stalled result word holds
    `STC_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_time_us) && $stable(m_run_state), "result word changed while stalled")

    // Input side only backs up when the result side is stalled
    `STC_ASSERT(a_backpressure, aclk, aresetn, !s_ready, m_valid && !m_ready, "input stalled without output stall")

    // A stop report always leaves the timer paused
    `STC_ASSERT(a_report_paused, aclk, aresetn, m_valid && m_stop_report, m_run_state == PH_PAUSED, "stop report without paused state")

    // Save request and stop report come from different commands
    `STC_ASSERT(a_save_xor_report, aclk, aresetn, m_valid && m_save_request, !m_stop_report, "save request and stop report together")

    // No result word right after reset
    `STC_ASSERT_NEXT_ANY(a_reset_empty, aclk, !aresetn, !m_valid, "result valid after reset")

endmodule

bind stopwatch_countdown_timer stc_checker u_stc_checker (.*);

`default_nettype wire
